>>> rtl/lftt_pkg.sv
// Shared types and constants for the login failure throttle table.
// No dependencies; imported by lftt_tunit and the top level.
`default_nettype none
package lftt_pkg;

  // Request kinds
  localparam logic [1:0] REQ_FAIL  = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_PURGE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_RETRY  = 2'd1;
  localparam logic [1:0] CFG_CAP    = 2'd2;
  localparam logic [1:0] CFG_WINDOW = 2'd3;

  localparam logic [4:0]  LIMIT_RST  = 5'd5;
  localparam logic [31:0] RETRY_RST  = 32'd1000;
  localparam logic [31:0] CAP_RST    = 32'd60000;
  localparam logic [31:0] WINDOW_RST = 32'd300000;

  localparam int KEY_W   = 64;
  localparam int CLASS_W = 2;
  localparam int TNOW_W  = 48;
  localparam int LIVE_W  = 7;

  typedef enum logic [1:0] {
    TU_ADD_SAT,
    TU_SUB
  } tu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH,
    S_ALLOC,
    S_LOAD,
    S_LOAD2,
    S_CHK,
    S_EDGE,
    S_DRD,
    S_DCMP,
    S_APP,
    S_SN1,
    S_SN2,
    S_SN3,
    S_WB,
    S_PNXT,
    S_PFIN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/lftt_tunit.sv
// Shared time arithmetic unit: saturating add or subtract with borrow.
// Depends on lftt_pkg.
`default_nettype none
module lftt_tunit import lftt_pkg::*; #(
  parameter int TW = 48
) (
  input  wire tu_op_t                       op,
  input  wire logic [((TW > 32) ? TW : 32)-1:0] a,
  input  wire logic [((TW > 32) ? TW : 32)-1:0] b,
  output logic [TW-1:0]                     res,
  output logic                              lt
);
  localparam int UW = (TW > 32) ? TW : 32;
  localparam logic [UW:0] TMAX = ((UW+1)'(1) << TW) - (UW+1)'(1);

  logic [UW:0] sum;
  logic [UW:0] diff;

  always_comb begin
    sum  = {1'b0, a} + {1'b0, b};
    diff = {1'b0, a} - {1'b0, b};
    lt   = diff[UW];
    case (op)
      TU_ADD_SAT: res = (sum > TMAX) ? {TW{1'b1}} : sum[TW-1:0];
      TU_SUB:     res = diff[TW-1:0];
      default:    res = diff[TW-1:0];
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/lftt_store.sv
// Table storage: key/class memory, per-entry count/oldest/next-allowed memory,
// and the timestamp ring memory. Single port each, registered read.
`default_nettype none
module lftt_store #(
  parameter int TE  = 64,
  parameter int MFK = 16,
  parameter int TW  = 48,
  parameter int EW  = 6,
  parameter int CW  = 5,
  parameter int OW  = 4,
  parameter int FA  = 10
) (
  input  wire logic          clk,
  input  wire logic [EW-1:0] k_addr,
  input  wire logic          k_we,
  input  wire logic [63:0]   k_wkey,
  input  wire logic [1:0]    k_wcls,
  output logic      [63:0]   k_rkey,
  output logic      [1:0]    k_rcls,
  input  wire logic [EW-1:0] m_addr,
  input  wire logic          m_we,
  input  wire logic [CW-1:0] m_wcnt,
  input  wire logic [OW-1:0] m_wold,
  input  wire logic [TW-1:0] m_wna,
  output logic      [CW-1:0] m_rcnt,
  output logic      [OW-1:0] m_rold,
  output logic      [TW-1:0] m_rna,
  input  wire logic [FA-1:0] f_addr,
  input  wire logic          f_we,
  input  wire logic [TW-1:0] f_wdata,
  output logic      [TW-1:0] f_rdata
);
  logic [65:0]        key_mem [TE];
  logic [CW+OW+TW-1:0] meta_mem [TE];
  logic [TW-1:0]      ft_mem  [TE*MFK];

  always_ff @(posedge clk) begin
    if (k_we) begin
      key_mem[k_addr] <= {k_wcls, k_wkey};
    end
    {k_rcls, k_rkey} <= key_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      meta_mem[m_addr] <= {m_wcnt, m_wold, m_wna};
    end
    {m_rcnt, m_rold, m_rna} <= meta_mem[m_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      ft_mem[f_addr] <= f_wdata;
    end
    f_rdata <= ft_mem[f_addr];
  end
endmodule
`default_nettype wire

>>> rtl/login_failure_throttle_table_unit.sv
// Top level of the login failure throttle table: sequencer, entry valid bits,
// configuration and result register. Uses lftt_pkg, lftt_tunit, lftt_store.
//
//  channel | direction | contents
//  in_     | slave     | tuser: req_type[1:0], key_class[3:2]; tdata: key[63:0], time_now[111:64]
//  out_    | master    | tdata: delayed[0], wait_time[32:1], status[33], live_entries[40:34]
//  cfg_    | write     | cfg_we, cfg_addr (register index), cfg_wdata
//
// Flow: one word at a time. A failure or check walks the key memory one entry a
// cycle, each compare in the cycle after its read; a failure then drops stale
// timestamps, appends now and sets the next allowed time, a check reports the
// wait left. A purge tick walks every entry, dropping stale timestamps and freeing
// emptied entries. The single time unit and single-port memories serialise steps.
// Reset (rst_n, synchronous) clears the valid bits and live count; stored keys
// and timestamps are only read once written. in_tready is low while a word is
// in work; a finished result holds in the output register until out_tready.
`default_nettype none
module login_failure_throttle_table_unit import lftt_pkg::*; #(
  parameter int TABLE_ENTRIES  = 64,
  parameter int MAX_FAILS_KEPT = 16,
  parameter int TIME_BITS      = 48
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,   // key[63:0], time_now[111:64]
  input  wire logic [3:0]   in_tuser,   // req_type[1:0], key_class[3:2]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata,  // delayed, wait_time, status, live_entries, zero pad
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);
  localparam int TE  = TABLE_ENTRIES;
  localparam int MFK = MAX_FAILS_KEPT;
  localparam int TW  = TIME_BITS;
  localparam int UW  = (TW > 32) ? TW : 32;
  localparam int EW  = $clog2(TE);
  localparam int CW  = $clog2(MFK + 1);
  localparam int OW  = (MFK > 1) ? $clog2(MFK) : 1;
  localparam int SW  = $clog2(2 * MFK);
  localparam int FA  = $clog2(TE * MFK);
  localparam int LCW = $clog2(TE + 1);

  // configuration
  logic [4:0]  limit_r;
  logic [31:0] retry_r, cap_r, window_r;

  state_t state_r, state_nxt;
  logic [1:0]     req_r, req_nxt;
  logic [1:0]     kc_r, kc_nxt;
  logic [63:0]    key_r, key_nxt;
  logic [TW-1:0]  now_r, now_nxt;
  logic [CW-1:0]  lim_r, lim_nxt;
  logic [EW:0]    idx_r, idx_nxt;
  logic           cmp_v_r, cmp_v_nxt;
  logic [EW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic           free_v_r, free_v_nxt;
  logic [EW-1:0]  free_idx_r, free_idx_nxt;
  logic [EW-1:0]  e_r, e_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [OW-1:0]  old_r, old_nxt;
  logic [TW-1:0]  na_r, na_nxt;
  logic [TW-1:0]  base_r, base_nxt;
  logic [TW-1:0]  edge_r, edge_nxt;
  logic           must_r, must_nxt;
  logic [TE-1:0]  valid_r, valid_nxt;
  logic [LCW-1:0] live_r, live_nxt;
  logic           dly_r, dly_nxt;
  logic [31:0]    wait_r, wait_nxt;
  logic           stat_r, stat_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [47:0]    out_data_r, out_data_nxt;

  // memory ports
  logic [EW-1:0] k_addr, m_addr;
  logic          k_we, m_we, f_we;
  logic [63:0]   k_rkey;
  logic [1:0]    k_rcls;
  logic [CW-1:0] m_rcnt;
  logic [OW-1:0] m_rold;
  logic [TW-1:0] m_rna;
  logic [FA-1:0] f_addr;
  logic [TW-1:0] f_rdata;

  // time unit
  tu_op_t        tu_op;
  logic [UW-1:0] tu_a, tu_b;
  logic [TW-1:0] tu_res;
  logic          tu_lt;
  logic [63:0]   tu_res64;
  logic [31:0]   tu_clamp;

  // ring slot addressing
  logic [CW-1:0] slot_i;
  logic [SW-1:0] slot_sum;
  logic [OW-1:0] slot_s;
  logic [OW-1:0] old_inc;

  logic [63:0]   tnow64;
  logic [6:0]    cfg_lim7;
  logic          hit;
  logic          in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign tnow64    = {16'd0, in_tdata[111:64]};
  assign cfg_lim7  = {2'd0, limit_r};

  lftt_tunit #(.TW(TW)) u_tunit (
    .op(tu_op), .a(tu_a), .b(tu_b), .res(tu_res), .lt(tu_lt)
  );

  lftt_store #(
    .TE(TE), .MFK(MFK), .TW(TW), .EW(EW), .CW(CW), .OW(OW), .FA(FA)
  ) u_store (
    .clk(clk),
    .k_addr(k_addr), .k_we(k_we), .k_wkey(key_r), .k_wcls(kc_r),
    .k_rkey(k_rkey), .k_rcls(k_rcls),
    .m_addr(m_addr), .m_we(m_we), .m_wcnt(cnt_r), .m_wold(old_r), .m_wna(na_r),
    .m_rcnt(m_rcnt), .m_rold(m_rold), .m_rna(m_rna),
    .f_addr(f_addr), .f_we(f_we), .f_wdata(now_r), .f_rdata(f_rdata)
  );

  assign tu_res64 = 64'(tu_res);
  assign tu_clamp = (|tu_res64[63:32]) ? 32'hFFFF_FFFF : tu_res64[31:0];

  // slot index (oldest + i) mod MFK, then flat address into the ring memory
  always_comb begin
    slot_i = (state_r == S_APP) ? ((cnt_r < lim_r) ? cnt_r : cnt_r - CW'(1)) : '0;
    slot_sum = SW'(old_r) + SW'(slot_i);
    if (slot_sum >= SW'(MFK)) begin
      slot_sum = slot_sum - SW'(MFK);
    end
    slot_s  = slot_sum[OW-1:0];
    f_addr  = FA'(e_r) * FA'(MFK) + FA'(slot_s);
    old_inc = (old_r == OW'(MFK - 1)) ? '0 : old_r + OW'(1);
  end

  assign hit = cmp_v_r && valid_r[cmp_idx_r] && (k_rcls == kc_r) && (k_rkey == key_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      retry_r  <= RETRY_RST;
      cap_r    <= CAP_RST;
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIMIT:  limit_r  <= cfg_wdata[4:0];
        CFG_RETRY:  retry_r  <= cfg_wdata;
        CFG_CAP:    cap_r    <= cfg_wdata;
        CFG_WINDOW: window_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    kc_nxt       = kc_r;
    key_nxt      = key_r;
    now_nxt      = now_r;
    lim_nxt      = lim_r;
    idx_nxt      = idx_r;
    cmp_v_nxt    = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    e_nxt        = e_r;
    cnt_nxt      = cnt_r;
    old_nxt      = old_r;
    na_nxt       = na_r;
    base_nxt     = base_r;
    edge_nxt     = edge_r;
    must_nxt     = must_r;
    valid_nxt    = valid_r;
    live_nxt     = live_r;
    dly_nxt      = dly_r;
    wait_nxt     = wait_r;
    stat_nxt     = stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    k_addr = e_r;
    k_we   = 1'b0;
    m_addr = e_r;
    m_we   = 1'b0;
    f_we   = 1'b0;
    tu_op  = TU_SUB;
    tu_a   = UW'(na_r);
    tu_b   = UW'(now_r);

    // drop the shown result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt  = in_tuser[1:0];
          kc_nxt   = in_tuser[3:2];
          key_nxt  = in_tdata[63:0];
          now_nxt  = tnow64[TW-1:0];
          lim_nxt  = (cfg_lim7 > 7'(MFK)) ? CW'(MFK) : CW'(limit_r);
          idx_nxt  = '0;
          free_v_nxt = 1'b0;
          dly_nxt  = 1'b0;
          wait_nxt = '0;
          stat_nxt = 1'b0;
          case (in_tuser[1:0])
            REQ_FAIL:  state_nxt = S_SRCH;
            REQ_CHECK: state_nxt = S_SRCH;
            REQ_PURGE: state_nxt = S_PNXT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end

      // walk the key memory; each compare comes in the cycle after its read
      S_SRCH: begin
        k_addr = idx_r[EW-1:0];
        if (idx_r < (EW+1)'(TE)) begin
          idx_nxt     = idx_r + (EW+1)'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[EW-1:0];
        end
        if (cmp_v_r) begin
          if (hit) begin
            e_nxt     = cmp_idx_r;
            cmp_v_nxt = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            if (!valid_r[cmp_idx_r] && !free_v_r) begin
              free_v_nxt   = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
            if (cmp_idx_r == EW'(TE - 1)) begin
              cmp_v_nxt = 1'b0;
              if (req_r == REQ_CHECK) begin
                state_nxt = S_DONE;
              end else if (free_v_nxt) begin
                e_nxt     = free_idx_nxt;
                state_nxt = S_ALLOC;
              end else begin
                stat_nxt  = 1'b1;
                state_nxt = S_DONE;
              end
            end
          end
        end
      end

      S_ALLOC: begin
        k_we = 1'b1;
        valid_nxt[e_r] = 1'b1;
        live_nxt = live_r + LCW'(1);
        cnt_nxt  = '0;
        old_nxt  = '0;
        na_nxt   = '0;
        state_nxt = (lim_r == '0) ? S_SN1 : S_EDGE;
      end

      S_LOAD: begin
        state_nxt = S_LOAD2;
      end

      S_LOAD2: begin
        cnt_nxt = m_rcnt;
        old_nxt = m_rold;
        na_nxt  = m_rna;
        case (req_r)
          REQ_FAIL:  state_nxt = (lim_r == '0) ? S_SN1 : S_EDGE;
          REQ_CHECK: state_nxt = S_CHK;
          default:   state_nxt = S_EDGE;
        endcase
      end

      // report remaining wait; re-extend only while still waiting
      S_CHK: begin
        if (tu_lt || tu_res == '0) begin
          state_nxt = S_DONE;
        end else begin
          wait_nxt  = tu_clamp;
          dly_nxt   = 1'b1;
          state_nxt = S_SN1;
        end
      end

      // window edge; skip dropping while now is short of the window
      S_EDGE: begin
        tu_a = UW'(now_r);
        tu_b = UW'(window_r);
        if (tu_lt) begin
          state_nxt = (req_r == REQ_PURGE) ? S_PFIN : S_APP;
        end else begin
          edge_nxt  = tu_res;
          state_nxt = S_DRD;
        end
      end

      S_DRD: begin
        if (cnt_r == '0) begin
          state_nxt = (req_r == REQ_PURGE) ? S_PFIN : S_APP;
        end else begin
          state_nxt = S_DCMP;
        end
      end

      S_DCMP: begin
        tu_a = UW'(f_rdata);
        tu_b = UW'(edge_r);
        if (tu_lt || tu_res == '0) begin
          old_nxt   = old_inc;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DRD;
        end else begin
          state_nxt = (req_r == REQ_PURGE) ? S_PFIN : S_APP;
        end
      end

      // append now, or overwrite the newest when full
      S_APP: begin
        f_we = 1'b1;
        if (cnt_r < lim_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = S_SN1;
      end

      S_SN1: begin
        must_nxt = (cnt_r >= lim_r);
        if (cnt_r >= lim_r) begin
          base_nxt  = tu_lt ? now_r : na_r;
          state_nxt = S_SN2;
        end else begin
          na_nxt    = now_r;
          state_nxt = S_WB;
        end
      end

      S_SN2: begin
        tu_op = TU_ADD_SAT;
        tu_a  = UW'(base_r);
        tu_b  = UW'(retry_r);
        base_nxt  = tu_res;
        state_nxt = S_SN3;
      end

      S_SN3: begin
        tu_op = TU_ADD_SAT;
        tu_a  = UW'(now_r);
        tu_b  = UW'(cap_r);
        na_nxt    = (base_r < tu_res) ? base_r : tu_res;
        state_nxt = S_WB;
      end

      S_WB: begin
        m_we = 1'b1;
        if (req_r == REQ_FAIL && must_r) begin
          dly_nxt  = 1'b1;
          wait_nxt = (tu_lt || tu_res == '0) ? '0 : tu_clamp;
        end
        state_nxt = S_DONE;
      end

      // purge walk over all entries
      S_PNXT: begin
        if (idx_r == (EW+1)'(TE)) begin
          state_nxt = S_DONE;
        end else if (valid_r[idx_r[EW-1:0]]) begin
          e_nxt     = idx_r[EW-1:0];
          state_nxt = S_LOAD;
        end else begin
          idx_nxt = idx_r + (EW+1)'(1);
        end
      end

      S_PFIN: begin
        m_we = 1'b1;
        if (cnt_r == '0) begin
          valid_nxt[e_r] = 1'b0;
          live_nxt = live_r - LCW'(1);
        end
        idx_nxt   = idx_r + (EW+1)'(1);
        state_nxt = S_PNXT;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, LIVE_W'(live_r), stat_r, wait_r, dly_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    kc_r       <= kc_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    lim_r      <= lim_nxt;
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    free_v_r   <= free_v_nxt;
    free_idx_r <= free_idx_nxt;
    e_r        <= e_nxt;
    cnt_r      <= cnt_nxt;
    old_r      <= old_nxt;
    na_r       <= na_nxt;
    base_r     <= base_nxt;
    edge_r     <= edge_nxt;
    must_r     <= must_nxt;
    dly_r      <= dly_nxt;
    wait_r     <= wait_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end
endmodule
`default_nettype wire
